### src/imu_encoder_frame_parser_top_macros.svh
// Assertion helpers used by the checker file
`ifndef IMU_ENCODER_FRAME_PARSER_TOP_MACROS_SVH
`define IMU_ENCODER_FRAME_PARSER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset
`define IMUEFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal is unchanged in the cycle after a condition
`define IMUEFP_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

### src/imuefp_pkg.sv
`timescale 1ns / 1ps

package imuefp_pkg;

    localparam int unsigned PAYLOAD_LEN = 16;
    localparam int unsigned NUM_WORDS   = PAYLOAD_LEN / 2;
    localparam int unsigned CNT_W       = $clog2(PAYLOAD_LEN);

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hF5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hFA;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_LEN - 1);

    typedef enum logic [0:0] {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_SECOND  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } cfg_t;

    typedef struct packed {
        logic [15:0] acc_x;
        logic [15:0] acc_y;
        logic [15:0] acc_z;
        logic [15:0] gyro_x;
        logic [15:0] gyro_y;
        logic [15:0] gyro_z;
        logic [15:0] enc_one;
        logic [15:0] enc_two;
    } frame_t;

endpackage

### src/imu_encoder_frame_parser_top.sv
`timescale 1ns / 1ps

// Frame parser for a two-byte-header serial stream of IMU and encoder data. One received
// byte is one item on the input channel; a byte can be taken in every clock cycle while
// in_ready is high. After the two header bytes (sync_first, sync_second) the next 16 bytes
// are gathered and one result of eight signed big-endian words leaves on the output channel,
// registered in the input byte register, then the output register. The output register
// frees the input side: in_ready drops only when the last byte of a frame meets a finished
// frame that is still waiting to be taken. Header registers are written through
// cfg_we/cfg_index/cfg_data and apply from the next header comparison.

module imu_encoder_frame_parser_top
    import imuefp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] acc_x,
    output logic signed [15:0] acc_y,
    output logic signed [15:0] acc_z,
    output logic signed [15:0] gyro_x,
    output logic signed [15:0] gyro_y,
    output logic signed [15:0] gyro_z,
    output logic signed [15:0] enc_one,
    output logic signed [15:0] enc_two
);

    cfg_t   cfg_reg;
    logic   res_valid;
    logic   res_busy;
    frame_t res_frame;
    frame_t out_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data;
                REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data;
                default: ;
            endcase
        end
    end

    imuefp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .res_busy  (res_busy),
        .res_valid (res_valid),
        .res_frame (res_frame)
    );

    imuefp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_frame (res_frame),
        .res_busy  (res_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_frame (out_frame)
    );

    assign acc_x   = $signed(out_frame.acc_x);
    assign acc_y   = $signed(out_frame.acc_y);
    assign acc_z   = $signed(out_frame.acc_z);
    assign gyro_x  = $signed(out_frame.gyro_x);
    assign gyro_y  = $signed(out_frame.gyro_y);
    assign gyro_z  = $signed(out_frame.gyro_z);
    assign enc_one = $signed(out_frame.enc_one);
    assign enc_two = $signed(out_frame.enc_two);

endmodule

### src/imuefp_ctrl.sv
`timescale 1ns / 1ps

module imuefp_ctrl
    import imuefp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       res_busy,
    output logic       res_valid,
    output frame_t     res_frame
);

    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [7:0]            store_reg [PAYLOAD_LEN-1];
    logic [7:0]            pb [PAYLOAD_LEN];
    logic                  last;
    logic                  stall;
    logic                  fire;

    assign last     = (phase_reg == PH_PAYLOAD) && (count_reg == CNT_LAST);
    assign stall    = in_vld_reg && last && res_busy;
    assign fire     = in_vld_reg && !stall;
    assign in_ready = !in_vld_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_comb
    begin
        phase_next = PH_HUNT;
        count_next = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                phase_next = (in_byte_reg == cfg.sync_first) ? PH_SECOND : PH_HUNT;
            end
            PH_SECOND:
            begin
                phase_next = (in_byte_reg == cfg.sync_second) ? PH_PAYLOAD : PH_HUNT;
            end
            PH_PAYLOAD:
            begin
                if (count_reg != CNT_LAST)
                begin
                    phase_next = PH_PAYLOAD;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // shift payload in, oldest byte at index 0
    always_ff @(posedge clk)
    begin
        if (fire && (phase_reg == PH_PAYLOAD))
        begin
            for (int i = 0; i < PAYLOAD_LEN - 2; i++)
            begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[PAYLOAD_LEN-2] <= in_byte_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < PAYLOAD_LEN - 1; i++)
        begin
            pb[i] = store_reg[i];
        end
        pb[PAYLOAD_LEN-1] = in_byte_reg;
    end

    assign res_valid         = fire && last;
    assign res_frame.acc_x   = {pb[0],  pb[1]};
    assign res_frame.acc_y   = {pb[2],  pb[3]};
    assign res_frame.acc_z   = {pb[4],  pb[5]};
    assign res_frame.gyro_x  = {pb[6],  pb[7]};
    assign res_frame.gyro_y  = {pb[8],  pb[9]};
    assign res_frame.gyro_z  = {pb[10], pb[11]};
    assign res_frame.enc_one = {pb[12], pb[13]};
    assign res_frame.enc_two = {pb[14], pb[15]};

endmodule

### src/imuefp_out.sv
`timescale 1ns / 1ps

module imuefp_out
    import imuefp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   res_valid,
    input  frame_t res_frame,
    output logic   res_busy,
    output logic   out_valid,
    input  logic   out_ready,
    output frame_t out_frame
);

    logic   valid_reg;
    frame_t frame_reg;

    assign res_busy  = valid_reg && !out_ready;
    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            frame_reg <= res_frame;
        end
    end

endmodule

### src/imuefp_checker.sv
`timescale 1ns / 1ps

`include "imu_encoder_frame_parser_top_macros.svh"

module imuefp_checker
    import imuefp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] acc_x,
    input logic signed [15:0] acc_y,
    input logic signed [15:0] acc_z,
    input logic signed [15:0] gyro_x,
    input logic signed [15:0] gyro_y,
    input logic signed [15:0] gyro_z,
    input logic signed [15:0] enc_one,
    input logic signed [15:0] enc_two
);

    logic         out_stall;
    logic         in_take;
    logic [127:0] out_bits;

    assign out_stall = out_valid && !out_ready;
    assign in_take   = in_valid && in_ready;
    assign out_bits  = {acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, enc_one, enc_two};

    `IMUEFP_HOLD(a_out_valid_hold, out_stall, out_valid, "item dropped while stalled")
    `IMUEFP_HOLD(a_out_data_hold, out_stall, out_bits, "item changed while stalled")
    `IMUEFP_ASSERT(a_ready_low_only_on_stall, !in_ready |-> out_stall, "input blocked")
    `IMUEFP_ASSERT(a_item_from_input, $rose(out_valid) |-> $past(in_take, 2), "item without byte")

endmodule

bind imu_encoder_frame_parser_top imuefp_checker u_chk (.*);

### tb/sv/tb_imu_encoder_frame_parser_top.sv
`timescale 1ns / 1ps

module tb_imu_encoder_frame_parser_top;
    import imuefp_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] enc_one;
    logic signed [15:0] enc_two;

    imu_encoder_frame_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .gyro_x    (gyro_x),
        .gyro_y    (gyro_y),
        .gyro_z    (gyro_z),
        .enc_one   (enc_one),
        .enc_two   (enc_two)
    );

    // Parser mirror
    logic [7:0]       hdr_first;
    logic [7:0]       hdr_second;
    phase_t           parse_phase;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       payload_bytes [PAYLOAD_LEN];
    frame_t           expected_frames [$];

    int errors         = 0;
    int bytes_sent     = 0;
    int frames_checked = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    bit sender_steady  = 1'b0;
    int holdoff_req    = 0;
    int idle_cycles    = 0;

    string word_names [8] = '{"acc_x", "acc_y", "acc_z", "gyro_x",
                              "gyro_y", "gyro_z", "enc_one", "enc_two"};

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void parse_byte(input logic [7:0] b);
        logic [16*NUM_WORDS-1:0] words;
        case (parse_phase)
            PH_SECOND:
            begin
                parse_phase = (b == hdr_second) ? PH_PAYLOAD : PH_HUNT;
                byte_count  = '0;
            end
            PH_PAYLOAD:
            begin
                payload_bytes[byte_count] = b;
                if (byte_count != CNT_LAST)
                begin
                    byte_count = byte_count + CNT_W'(1);
                end
                else
                begin
                    words = '0;
                    for (int k = 0; k < NUM_WORDS; k++)
                    begin
                        words = {words[16*NUM_WORDS-17:0],
                                 payload_bytes[2*k], payload_bytes[2*k+1]};
                    end
                    expected_frames.push_back(frame_t'(words));
                    parse_phase = PH_HUNT;
                    byte_count  = '0;
                end
            end
            default:
            begin
                parse_phase = (b == hdr_first) ? PH_SECOND : PH_HUNT;
                byte_count  = '0;
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return hdr_first;
            3:       return hdr_second;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(1, 4);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        send_byte(hdr_first);
        send_byte(hdr_second);
        repeat (PAYLOAD_LEN) send_byte(rand_byte());
    endtask

    // Drop valid, wait for every frame, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SYNC_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= REG_SYNC_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hdr_first  = first;
        hdr_second = second;
    endtask

    task automatic test_directed_frame();
        logic [7:0] head_part [10] = '{8'hF5, 8'hFA, 8'h80, 8'h00, 8'h7F,
                                       8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        logic [7:0] tail_part [8]  = '{8'hF5, 8'hFA, 8'hFA, 8'hF5,
                                       8'h01, 8'h80, 8'h5A, 8'hA5};
        foreach (head_part[i]) send_byte(head_part[i]);
        // Change the headers halfway through the payload
        settle();
        set_headers(8'h00, 8'hFF);
        settings_used++;
        foreach (tail_part[i]) send_byte(tail_part[i]);
        settle();
    endtask

    task automatic test_repeated_first_header();
        send_byte(hdr_first);
        send_byte(hdr_first);
        send_byte(hdr_second);
        settle();
    endtask

    task automatic test_backpressure();
        holdoff_req   = 300;
        sender_steady = 1'b1;
        repeat (4) send_frame();
        sender_steady = 1'b0;
        settle();
    endtask

    task automatic test_random_stream(input logic [7:0] first, input logic [7:0] second,
                                      input int n_items);
        int         start;
        int         pick;
        logic [7:0] junk;
        settle();
        set_headers(first, second);
        settings_used++;
        start = bytes_sent;
        while (bytes_sent - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_frame();
            end
            else if (pick < 85)
            begin
                send_byte(hdr_first);
                junk = rand_byte();
                send_byte((junk == hdr_second) ? ~junk : junk);
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 5)) send_byte(rand_byte());
            end
            else
            begin
                send_byte(hdr_first);
                send_byte(hdr_first);
                send_byte(hdr_second);
            end
        end
    endtask

    // Receiver: stall on a changing pattern, hold off on request
    initial
    begin
        int rx_mode;
        int mode_left;
        int pat_cnt;
        int hold_len;
        rx_mode   = 0;
        mode_left = 0;
        pat_cnt   = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (holdoff_req != 0)
            begin
                hold_len    = holdoff_req;
                holdoff_req = 0;
                out_ready  <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((pat_cnt % 8) < 5);
                endcase
                pat_cnt++;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        frame_t got;
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, enc_one, enc_two};
            if (expected_frames.size() == 0)
            begin
                $display("%0t unexpected frame: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_frames.pop_front();
                for (int k = 0; k < NUM_WORDS; k++)
                begin
                    if (got[127-16*k -: 16] !== want[127-16*k -: 16])
                    begin
                        $display("%0t mismatch %s: expected %h, actual %h", $time,
                                 word_names[k], want[127-16*k -: 16], got[127-16*k -: 16]);
                        errors++;
                    end
                end
                frames_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] same_hdr;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SYNC_FIRST;
        cfg_data    = 8'h00;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        hdr_first   = SYNC_FIRST_RST;
        hdr_second  = SYNC_SECOND_RST;
        parse_phase = PH_HUNT;
        byte_count  = '0;
        foreach (payload_bytes[i]) payload_bytes[i] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frame();
        test_repeated_first_header();
        test_backpressure();
        test_random_stream(SYNC_FIRST_RST, SYNC_SECOND_RST, 380);
        test_random_stream(8'hFF, 8'h00, 380);
        test_random_stream(8'h00, 8'hFF, 360);
        same_hdr = 8'($urandom_range(0, 255));
        test_random_stream(same_hdr, same_hdr, 360);
        test_random_stream(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 360);

        in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            $display("%0t %0d frames expected but never seen", $time, expected_frames.size());
            errors++;
        end
        $display("Sent %0d bytes under %0d header settings, checked %0d frames.",
                 bytes_sent, settings_used, frames_checked);
        $display("Covered broken and repeated headers, mid-frame writes and long back-pressure.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
